// File: rtl/joint_setpoint_smoother_defines.svh
// Assertion helpers for the smoother RTL.
`ifndef JOINT_SETPOINT_SMOOTHER_DEFINES_SVH
`define JOINT_SETPOINT_SMOOTHER_DEFINES_SVH

// Same-cycle implication.
`define JSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/jss_pkg.sv
package jss_pkg;

  localparam int JOINTS_DEF      = 6;
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int OUT_JOINTS      = 6;

  // 2pi and the 0.01 rad snap window in angle units
  localparam logic [63:0] TWO_PI_Q =
    (64'd26986075409 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
  localparam logic [63:0] SNAP_Q =
    (64'd42949673 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);

  // Wrap by restoring reduction: offset by 2pi << WRAP_SH, then strip multiples
  localparam int          WRAP_SH  = $clog2(((64'd1 << 31) / TWO_PI_Q) + 64'd1);
  localparam logic [63:0] WRAP_OFS = TWO_PI_Q << WRAP_SH;
  localparam int          WRAP_W   = 36;
  localparam int          WRAP_SW  = WRAP_W + 1;

  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int ACC_W      = 66;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [2:0] CFG_GAIN      = 3'd0;
  localparam logic [2:0] CFG_TIME_STEP = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_RAMP_RATE = 3'd3;
  localparam logic [2:0] CFG_CRUISE    = 3'd4;

  localparam logic [15:0] GAIN_RST   = 16'd655;
  localparam logic [15:0] TSTEP_RST  = 16'd66;
  localparam logic [30:0] THRESH_RST = 31'd16777;
  localparam logic [15:0] RATE_RST   = 16'd328;
  localparam logic [30:0] CRUISE_RST = 31'd10066330;

  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         joint_index;
    logic signed [31:0] target_angle;
    logic               use_second_order;
    logic signed [31:0] measured_joint_0;
    logic signed [31:0] measured_joint_1;
    logic signed [31:0] measured_joint_2;
    logic signed [31:0] measured_joint_3;
    logic signed [31:0] measured_joint_4;
    logic signed [31:0] measured_joint_5;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] setpoint_0;
    logic signed [31:0] setpoint_1;
    logic signed [31:0] setpoint_2;
    logic signed [31:0] setpoint_3;
    logic signed [31:0] setpoint_4;
    logic signed [31:0] setpoint_5;
    logic               arrived;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_WRAP, ST_SEED, ST_ERRSQ, ST_ERRSUM, ST_CHECK,
    ST_LAG1, ST_LAG2, ST_SPEED, ST_SSTEP, ST_MAG, ST_MAX, ST_MAGSQ,
    ST_MAGSUM, ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT, ST_DIV, ST_MOVE, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    LC_IDLE, LC_LOAD, LC_WRAP_INIT, LC_WRAP_STEP, LC_SEED, LC_ERRSQ, LC_LAG1,
    LC_LAG2, LC_MAG, LC_MAGSQ, LC_DIV_INIT, LC_DIV_STEP, LC_MOVE
  } lane_cmd_t;

  typedef enum logic [2:0] {
    MC_IDLE, MC_CLR, MC_SUM, MC_MAX, MC_SQRT_INIT, MC_SQRT_STEP
  } merge_cmd_t;

  typedef struct packed {
    lane_cmd_t          cmd;
    logic [5:0]         step;
    logic [2:0]         ld_idx;
    logic signed [31:0] ld_val;
    logic [15:0]        gain;
    logic [1:0]         k;
    logic               neg_step;
    logic [31:0]        sm;
    logic [31:0]        root;
  } lane_ctl_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [31:0]      root;
  } merge_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/jss_lane.sv
module jss_lane
  import jss_pkg::*;
#(
  parameter int LANE_ID = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctl_t          ctl,
  input  logic signed [31:0] meas,
  output logic signed [31:0] sp_lag,
  output logic signed [31:0] sp_ramp,
  output logic [63:0]        sq,
  output logic [32:0]        mag
);

  logic signed [31:0] tgt_r, first_r, second_r, pos_r;
  logic [WRAP_W-1:0]  wm_r, wt_r;
  logic [63:0]        sq_r;
  logic signed [32:0] dv_r;
  logic [32:0]        mag_r;
  logic [29:0]        magk_r;
  logic [61:0]        dvd_r;
  logic [31:0]        rem_r;

  logic [WRAP_W-1:0]    wstep, wm_red, wt_red;
  logic signed [WRAP_W:0] cw, tw, lo, hi, d_full;
  logic                 snap;
  logic signed [31:0]   d32;
  logic signed [63:0]   errsq;
  logic signed [32:0]   lag_diff;
  logic signed [49:0]   lag_prod, lag_rnd;
  logic signed [31:0]   lag_a, lag_b, lag_new;
  logic signed [32:0]   dv_c;
  logic [29:0]          magk_c;
  logic [31:0]          rem_src;
  logic [32:0]          rem_sh;
  logic                 ge;
  logic signed [39:0]   delta;

  always_comb begin
    wstep  = WRAP_W'(TWO_PI_Q << ctl.step);
    wm_red = (wm_r >= wstep) ? wm_r - wstep : wm_r;
    wt_red = (wt_r >= wstep) ? wt_r - wstep : wt_r;

    cw     = $signed({1'b0, wm_r});
    tw     = $signed({1'b0, wt_r});
    lo     = tw - $signed(WRAP_SW'(SNAP_Q));
    hi     = tw + $signed(WRAP_SW'(SNAP_Q));
    snap   = (cw >= lo) && (cw <= hi);
    d_full = cw - tw;
    d32    = d_full[31:0];
    errsq  = d32 * d32;

    // one multiplier serves both lag stages
    lag_a    = (ctl.cmd == LC_LAG2) ? first_r : tgt_r;
    lag_b    = (ctl.cmd == LC_LAG2) ? second_r : first_r;
    lag_diff = 33'(lag_a) - 33'(lag_b);
    lag_prod = $signed({1'b0, ctl.gain}) * lag_diff;
    lag_rnd  = (lag_prod + 50'sd32768) >>> 16;
    lag_new  = sat32(40'(lag_b) + 40'(lag_rnd));

    dv_c   = 33'(tgt_r) - 33'(pos_r);
    magk_c = 30'(mag_r >> ctl.k);

    rem_src = (ctl.step == '0) ? {2'b00, dvd_r[61:32]} : rem_r;
    rem_sh  = {rem_src, dvd_r[31]};
    ge      = rem_sh >= {1'b0, ctl.root};

    delta = (dv_r[32] != ctl.neg_step) ? -40'($signed({8'd0, dvd_r[31:0]}))
                                       : 40'($signed({8'd0, dvd_r[31:0]}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
      pos_r    <= '0;
    end else begin
      case (ctl.cmd)
        LC_LOAD: begin
          if (ctl.ld_idx == 3'(LANE_ID)) tgt_r <= ctl.ld_val;
        end
        LC_SEED: begin
          first_r  <= snap ? tgt_r : meas;
          second_r <= snap ? tgt_r : meas;
          pos_r    <= snap ? tgt_r : meas;
        end
        LC_LAG1: first_r <= lag_new;
        LC_LAG2: second_r <= lag_new;
        LC_MOVE: pos_r <= sat32(40'(pos_r) + delta);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      LC_WRAP_INIT: begin
        wm_r <= WRAP_W'(WRAP_OFS) + WRAP_W'(meas);
        wt_r <= WRAP_W'(WRAP_OFS) + WRAP_W'(tgt_r);
      end
      LC_WRAP_STEP: begin
        wm_r <= wm_red;
        wt_r <= wt_red;
      end
      LC_ERRSQ: sq_r <= errsq;
      LC_MAG: begin
        dv_r  <= dv_c;
        mag_r <= dv_c[32] ? 33'(-dv_c) : dv_c;
      end
      LC_MAGSQ: begin
        magk_r <= magk_c;
        sq_r   <= 64'(magk_c) * 64'(magk_c);
      end
      LC_DIV_INIT: dvd_r <= ctl.sm * magk_r;
      LC_DIV_STEP: begin
        rem_r        <= ge ? 32'(rem_sh - {1'b0, ctl.root}) : rem_sh[31:0];
        dvd_r[31:0]  <= {dvd_r[30:0], ge};
      end
      default: ;
    endcase
  end

  assign sp_lag  = second_r;
  assign sp_ramp = pos_r;
  assign sq      = sq_r;
  assign mag     = mag_r;

endmodule

// File: rtl/jss_merge.sv
module jss_merge
  import jss_pkg::*;
#(
  parameter int JOINTS = JOINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  merge_cmd_t   cmd,
  input  logic [63:0]  sq   [JOINTS],
  input  logic [32:0]  mag  [JOINTS],
  output merge_stat_t  stat
);

  localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  logic [IW-1:0]    idx_r;
  logic [ACC_W-1:0] acc_r;
  logic [63:0]      x_r, res_r, bit_r;
  logic [63:0]      trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      case (cmd)
        MC_CLR:  idx_r <= '0;
        MC_SUM,
        MC_MAX:  idx_r <= idx_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      MC_CLR: acc_r <= '0;
      MC_SUM: acc_r <= acc_r + ACC_W'(sq[idx_r]);
      MC_MAX: begin
        if (ACC_W'(mag[idx_r]) > acc_r) acc_r <= ACC_W'(mag[idx_r]);
      end
      MC_SQRT_INIT: begin
        x_r   <= acc_r[63:0];
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      MC_SQRT_STEP: begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
  end

  assign stat.acc  = acc_r;
  assign stat.root = res_r[31:0];

endmodule

// File: rtl/joint_setpoint_smoother.sv
// Load writes one target. Start wraps the angles and seeds the filters.
// Tick wraps and sums the squared error; when arrived it emits, in lag mode it runs
// both lag stages, in ramp mode it moves each position toward its target; the bit-serial
// square root and the per-lane dividers, one bit a cycle each, set the ramp move.
// One item is worked at a time; a new one is taken while a result waits.
// Reset (synchronous, rst_n low) clears targets, filter state, speed, mode.
`include "joint_setpoint_smoother_defines.svh"

module joint_setpoint_smoother
  import jss_pkg::*;
#(
  parameter int JOINTS = JOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  // configuration registers
  logic [15:0] gain_r, tstep_r, rate_r;
  logic [30:0] thresh_r, cruise_r;

  in_word_t           item_r;
  logic               lag_mode_r;
  logic signed [31:0] speed_r, sstep_r;
  logic [61:0]        thr2_r;
  logic               arrived_r;
  out_word_t          out_r;
  logic               out_valid_r;

  lane_ctl_t   lane_ctl;
  merge_cmd_t  merge_cmd;
  merge_stat_t merge_st;

  logic signed [31:0] sp_lag  [JOINTS];
  logic signed [31:0] sp_ramp [JOINTS];
  logic [63:0]        sq      [JOINTS];
  logic [32:0]        mag     [JOINTS];
  logic signed [31:0] meas6   [OUT_JOINTS];
  logic signed [31:0] sp6     [OUT_JOINTS];

  logic               in_fire, emit_go;
  logic signed [32:0] spd_diff;
  logic signed [49:0] spd_prod, spd_rnd;
  logic signed [48:0] ss_prod, ss_rnd;
  logic [1:0]         k_c;
  out_word_t          out_c;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  // --- lanes: one per joint, each holds its own target and filter paths
  always_comb begin
    meas6[0] = item_r.measured_joint_0;
    meas6[1] = item_r.measured_joint_1;
    meas6[2] = item_r.measured_joint_2;
    meas6[3] = item_r.measured_joint_3;
    meas6[4] = item_r.measured_joint_4;
    meas6[5] = item_r.measured_joint_5;
  end

  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    logic signed [31:0] lane_meas;
    if (j < OUT_JOINTS) begin : g_m
      assign lane_meas = meas6[j];
    end else begin : g_z
      // joints beyond the word's six read a measured angle of zero
      assign lane_meas = '0;
    end
    jss_lane #(.LANE_ID(j)) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (lane_ctl),
      .meas    (lane_meas),
      .sp_lag  (sp_lag[j]),
      .sp_ramp (sp_ramp[j]),
      .sq      (sq[j]),
      .mag     (mag[j])
    );
  end

  // --- merge: sums, maximum and square root across the lanes
  jss_merge #(.JOINTS(JOINTS)) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (merge_cmd),
    .sq    (sq),
    .mag   (mag),
    .stat  (merge_st)
  );

  // --- next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.operation == OP_START || in_data.operation == OP_TICK)) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        state_nxt = ST_WRAP;
        cnt_nxt   = 6'(WRAP_SH);
      end
      ST_WRAP: begin
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) state_nxt = (item_r.operation == OP_START) ? ST_SEED : ST_ERRSQ;
      end
      ST_SEED:  state_nxt = ST_IDLE;
      ST_ERRSQ: begin
        state_nxt = ST_ERRSUM;
        cnt_nxt   = '0;
      end
      ST_ERRSUM: begin
        if (cnt_r == 6'(JOINTS - 1)) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (merge_st.acc <= ACC_W'(thr2_r)) state_nxt = ST_EMIT;
        else if (lag_mode_r) state_nxt = ST_LAG1;
        else state_nxt = ST_SPEED;
      end
      ST_LAG1:  state_nxt = ST_LAG2;
      ST_LAG2:  state_nxt = ST_EMIT;
      ST_SPEED: state_nxt = ST_SSTEP;
      ST_SSTEP: state_nxt = ST_MAG;
      ST_MAG: begin
        state_nxt = ST_MAX;
        cnt_nxt   = '0;
      end
      ST_MAX: begin
        if (cnt_r == 6'(JOINTS - 1)) state_nxt = ST_MAGSQ;
      end
      ST_MAGSQ: begin
        state_nxt = ST_MAGSUM;
        cnt_nxt   = '0;
      end
      ST_MAGSUM: begin
        if (cnt_r == 6'(JOINTS - 1)) state_nxt = ST_SQRT_INIT;
      end
      ST_SQRT_INIT: begin
        state_nxt = ST_SQRT;
        cnt_nxt   = '0;
      end
      ST_SQRT: begin
        if (cnt_r == 6'(ROOT_STEPS - 1)) state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        // zero distance: hold every position
        state_nxt = (merge_st.root == '0) ? ST_EMIT : ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = ST_MOVE;
      end
      ST_MOVE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --- control words for lanes and merge
  always_comb begin
    k_c = merge_st.acc[32] ? 2'd3 : merge_st.acc[31] ? 2'd2 : merge_st.acc[30] ? 2'd1 : 2'd0;

    lane_ctl.cmd      = LC_IDLE;
    lane_ctl.step     = cnt_r;
    lane_ctl.ld_idx   = in_data.joint_index;
    lane_ctl.ld_val   = in_data.target_angle;
    lane_ctl.gain     = gain_r;
    lane_ctl.k        = k_c;
    lane_ctl.neg_step = sstep_r[31];
    lane_ctl.sm       = sstep_r[31] ? 32'(-sstep_r) : sstep_r;
    lane_ctl.root     = merge_st.root;
    merge_cmd         = MC_IDLE;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.operation == OP_LOAD) lane_ctl.cmd = LC_LOAD;
      end
      ST_INIT:   lane_ctl.cmd = LC_WRAP_INIT;
      ST_WRAP:   lane_ctl.cmd = LC_WRAP_STEP;
      ST_SEED:   lane_ctl.cmd = LC_SEED;
      ST_ERRSQ: begin
        lane_ctl.cmd = LC_ERRSQ;
        merge_cmd    = MC_CLR;
      end
      ST_ERRSUM: merge_cmd = MC_SUM;
      ST_LAG1:   lane_ctl.cmd = LC_LAG1;
      ST_LAG2:   lane_ctl.cmd = LC_LAG2;
      ST_MAG: begin
        lane_ctl.cmd = LC_MAG;
        merge_cmd    = MC_CLR;
      end
      ST_MAX:    merge_cmd = MC_MAX;
      ST_MAGSQ: begin
        // shift taken from the maximum; clear the sum on the same edge
        lane_ctl.cmd = LC_MAGSQ;
        merge_cmd    = MC_CLR;
      end
      ST_MAGSUM:    merge_cmd = MC_SUM;
      ST_SQRT_INIT: merge_cmd = MC_SQRT_INIT;
      ST_SQRT:      merge_cmd = MC_SQRT_STEP;
      ST_DIV_INIT: begin
        if (merge_st.root != '0) lane_ctl.cmd = LC_DIV_INIT;
      end
      ST_DIV:    lane_ctl.cmd = LC_DIV_STEP;
      ST_MOVE:   lane_ctl.cmd = LC_MOVE;
      default: ;
    endcase
  end

  // --- speed ramp arithmetic
  always_comb begin
    spd_diff = $signed({2'b00, cruise_r}) - 33'(speed_r);
    spd_prod = $signed({1'b0, rate_r}) * spd_diff;
    spd_rnd  = (spd_prod + 50'sd32768) >>> 16;
    ss_prod  = $signed({1'b0, tstep_r}) * speed_r;
    ss_rnd   = (ss_prod + 49'sd32768) >>> 16;
  end

  // --- result word: setpoints of the active path
  for (genvar j = 0; j < OUT_JOINTS; j++) begin : g_out
    if (j < JOINTS) begin : g_live
      assign sp6[j] = lag_mode_r ? sp_lag[j] : sp_ramp[j];
    end else begin : g_none
      assign sp6[j] = '0;
    end
  end

  always_comb begin
    out_c.setpoint_0 = sp6[0];
    out_c.setpoint_1 = sp6[1];
    out_c.setpoint_2 = sp6[2];
    out_c.setpoint_3 = sp6[3];
    out_c.setpoint_4 = sp6[4];
    out_c.setpoint_5 = sp6[5];
    out_c.arrived    = arrived_r;
  end

  // --- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      lag_mode_r  <= 1'b0;
      speed_r     <= '0;
      gain_r      <= GAIN_RST;
      tstep_r     <= TSTEP_RST;
      thresh_r    <= THRESH_RST;
      rate_r      <= RATE_RST;
      cruise_r    <= CRUISE_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_SEED) begin
        lag_mode_r <= item_r.use_second_order;
        speed_r    <= '0;
      end
      if (state_r == ST_SPEED) speed_r <= sat32(40'(speed_r) + 40'(spd_rnd));
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:      gain_r   <= cfg_data[15:0];
          CFG_TIME_STEP: tstep_r  <= cfg_data[15:0];
          CFG_THRESHOLD: thresh_r <= cfg_data;
          CFG_RAMP_RATE: rate_r   <= cfg_data[15:0];
          CFG_CRUISE:    cruise_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // --- payload registers
  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_data;
    if (state_r == ST_ERRSQ) thr2_r <= thresh_r * thresh_r;
    if (state_r == ST_CHECK) arrived_r <= merge_st.acc <= ACC_W'(thr2_r);
    if (state_r == ST_SSTEP) sstep_r <= 32'(ss_rnd);
    if (emit_go) out_r <= out_c;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `JSS_ASSERT_NEXT(a_tick_starts, in_fire && in_data.operation == OP_TICK, state_r == ST_INIT, "tick word did not start the sequence")
  `JSS_ASSERT_NEXT(a_load_single, in_fire && in_data.operation == OP_LOAD, state_r == ST_IDLE, "load word did not finish in one cycle")
  `JSS_ASSERT_NEXT(a_zero_root_hold, state_r == ST_DIV_INIT && merge_st.root == '0, state_r == ST_EMIT, "zero distance did not skip the move")
  `JSS_ASSERT_NEXT(a_emit_loads, state_r == ST_EMIT && !out_valid_r, out_valid_r && state_r == ST_IDLE, "free output not loaded")

endmodule
